// ===== rtl/core/lzwvd_pkg.sv =====
package lzwvd_pkg;

    // Reserved codes and the first entry that the dictionary hands out.
    localparam int unsigned CODE_CLEAR = 256;
    localparam int unsigned CODE_END = 257;
    localparam int unsigned FIRST_FREE = 258;

    // Codes below this value stand for a single byte.
    localparam int unsigned LIT_LIMIT = 256;

    // Code width and growth threshold right after reset or a clear code.
    localparam int unsigned START_WIDTH = 9;
    localparam int unsigned START_THRESHOLD = 512;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CW_W = 4;
    localparam int unsigned BYTES_PER_RESULT = 8;
    localparam int unsigned OUT_W = 64;
    localparam int unsigned BCNT_W = 4;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_WALK   = 7'b0000100,
        S_TAIL   = 7'b0001000,
        S_FINISH = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

endpackage

// ===== rtl/core/lzwvd_dict.sv =====
module lzwvd_dict
    import lzwvd_pkg::*;
#(
    parameter int CODE_W = 12
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [CODE_W-1:0] waddr,
    input  logic [CODE_W-1:0] wprefix,
    input  logic [BYTE_W-1:0] wsuffix,
    input  logic              re,
    input  logic [CODE_W-1:0] raddr,
    output logic [CODE_W-1:0] rprefix,
    output logic [BYTE_W-1:0] rsuffix
);

    localparam int DEPTH = 1 << CODE_W;

    // Prefix and suffix halves of each dictionary entry, one write and one
    // registered read per cycle.
    logic [CODE_W-1:0] prefix_mem [DEPTH];
    logic [BYTE_W-1:0] suffix_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            prefix_mem[waddr] <= wprefix;
            suffix_mem[waddr] <= wsuffix;
        end
        if (re)
        begin
            rprefix <= prefix_mem[raddr];
            rsuffix <= suffix_mem[raddr];
        end
    end

endmodule

// ===== rtl/core/lzw_variable_width_decoder.sv =====
// A byte that completes no code is taken while the block stays idle. A byte that completes a
// code moves on to a decode step, a prefix walk over the decoded string, a dictionary update,
// and then, for each result of up to eight bytes, a packing pass over the string stack and the
// output register, which holds its result while the receiver stalls.
// Throughput: one request at a time; the dictionary read port sets the walk at one byte
// per cycle. Reset clears all control state; the dictionary and the string stack hold
// whatever was last written and need no clearing pass.
module lzw_variable_width_decoder
    import lzwvd_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12,
    parameter int MAX_STRING = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       out_bytes,
    output logic [3:0]        byte_count,
    output logic              last_of_run,
    output logic              end_seen,
    output logic              overflow_error
);

    localparam int CODE_W = MAX_CODE_BITS;
    localparam int FREE_W = MAX_CODE_BITS + 1;
    localparam int TABLE_SIZE = 1 << MAX_CODE_BITS;
    // A byte arrives only while fewer than code_width bits are held.
    localparam int BUF_W = MAX_CODE_BITS + BYTE_W;
    localparam int HELD_W = $clog2(BUF_W + 1);
    localparam int STK_AW = $clog2(MAX_STRING);
    localparam int CNT_W = $clog2(MAX_STRING + 1);

    // Control state.
    state_t              state_reg, state_next;
    logic [BUF_W-1:0]    bit_buffer_reg, bit_buffer_next;
    logic [HELD_W-1:0]   bits_held_reg, bits_held_next;
    logic [CW_W-1:0]     code_width_reg, code_width_next;
    logic [FREE_W-1:0]   next_free_reg, next_free_next;
    logic [FREE_W-1:0]   threshold_reg, threshold_next;
    logic [CODE_W-1:0]   prev_code_reg, prev_code_next;
    logic [BYTE_W-1:0]   prev_first_reg, prev_first_next;
    logic                have_prev_reg, have_prev_next;
    logic                expect_lit_reg, expect_lit_next;
    logic                done_reg, done_next;

    // Working registers of one decoded code.
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                known_reg, known_next;
    logic [CODE_W-1:0]   walk_code_reg, walk_code_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [BCNT_W-1:0]   issued_reg, issued_next;
    logic [BCNT_W-1:0]   packed_reg, packed_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [OUT_W-1:0]    word_reg, word_next;

    // Result register.
    logic [OUT_W-1:0]    out_bytes_reg, out_bytes_next;
    logic [BCNT_W-1:0]   byte_count_reg, byte_count_next;
    logic                last_reg, last_next;
    logic                end_reg, end_next;
    logic                err_reg, err_next;

    // String stack: the walk pushes bytes last first, the packer pops them.
    logic [BYTE_W-1:0]   stack_mem [MAX_STRING];
    logic                stk_we;
    logic [STK_AW-1:0]   stk_waddr;
    logic [BYTE_W-1:0]   stk_wdata;
    logic                stk_re;
    logic [STK_AW-1:0]   stk_raddr;
    logic [BYTE_W-1:0]   stk_q;

    // Dictionary port signals.
    logic                tbl_we;
    logic [CODE_W-1:0]   tbl_waddr;
    logic [BYTE_W-1:0]   tbl_wsuffix;
    logic                tbl_re;
    logic [CODE_W-1:0]   tbl_raddr;
    logic [CODE_W-1:0]   tbl_prefix_q;
    logic [BYTE_W-1:0]   tbl_suffix_q;

    // The bit unpacker works on the request in the same cycle it is taken.
    logic [BUF_W-1:0]    buf_merged;
    logic [HELD_W-1:0]   held_sum;
    logic                have_code;
    logic [CODE_W-1:0]   code_now;

    always_comb
    begin
        buf_merged = bit_buffer_reg | (BUF_W'(in_byte) << bits_held_reg);
        held_sum = bits_held_reg + HELD_W'(BYTE_W);
        have_code = held_sum >= HELD_W'(code_width_reg);
        for (int j = 0; j < CODE_W; j++)
        begin
            code_now[j] = buf_merged[j] & (j < int'(code_width_reg));
        end
    end

    lzwvd_dict #(
        .CODE_W (CODE_W)
    ) u_dict (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wprefix (prev_code_reg),
        .wsuffix (tbl_wsuffix),
        .re      (tbl_re),
        .raddr   (tbl_raddr),
        .rprefix (tbl_prefix_q),
        .rsuffix (tbl_suffix_q)
    );

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_q <= stack_mem[stk_raddr];
        end
    end

    always_comb
    begin
        logic              is_known;
        logic [CODE_W-1:0] walk_start;
        logic [FREE_W-1:0] free_inc;
        logic              add_ok;
        logic [CNT_W-1:0]  remain_dec;
        logic [OUT_W-1:0]  word_acc;
        logic [BCNT_W-1:0] packed_acc;
        logic              issue;

        state_next      = state_reg;
        bit_buffer_next = bit_buffer_reg;
        bits_held_next  = bits_held_reg;
        code_width_next = code_width_reg;
        next_free_next  = next_free_reg;
        threshold_next  = threshold_reg;
        prev_code_next  = prev_code_reg;
        prev_first_next = prev_first_reg;
        have_prev_next  = have_prev_reg;
        expect_lit_next = expect_lit_reg;
        done_next       = done_reg;
        code_next       = code_reg;
        known_next      = known_reg;
        walk_code_next  = walk_code_reg;
        depth_next      = depth_reg;
        remain_next     = remain_reg;
        issued_next     = issued_reg;
        packed_next     = packed_reg;
        rd_pend_next    = rd_pend_reg;
        word_next       = word_reg;
        out_bytes_next  = out_bytes_reg;
        byte_count_next = byte_count_reg;
        last_next       = last_reg;
        end_next        = end_reg;
        err_next        = err_reg;

        stk_we    = 1'b0;
        stk_waddr = depth_reg[STK_AW-1:0];
        stk_wdata = walk_code_reg[BYTE_W-1:0];
        stk_re    = 1'b0;
        remain_dec = remain_reg - CNT_W'(1);
        stk_raddr = remain_dec[STK_AW-1:0];

        tbl_we      = 1'b0;
        tbl_waddr   = next_free_reg[CODE_W-1:0];
        tbl_wsuffix = known_reg ? walk_code_reg[BYTE_W-1:0] : prev_first_reg;
        tbl_re      = 1'b0;
        tbl_raddr   = tbl_prefix_q;

        is_known = (code_reg < CODE_W'(LIT_LIMIT))
            || ((code_reg >= CODE_W'(FIRST_FREE)) && (FREE_W'(code_reg) < next_free_reg));
        walk_start = is_known ? code_reg : prev_code_reg;
        free_inc = next_free_reg + FREE_W'(1);
        add_ok = next_free_reg < FREE_W'(TABLE_SIZE);

        word_acc = word_reg;
        if (rd_pend_reg)
        begin
            for (int j = 0; j < int'(BYTES_PER_RESULT); j++)
            begin
                if (packed_reg == BCNT_W'(j))
                begin
                    word_acc[j*BYTE_W +: BYTE_W] = stk_q;
                end
            end
        end
        packed_acc = packed_reg + BCNT_W'(rd_pend_reg);
        issue = (remain_reg != '0) && (issued_reg != BCNT_W'(BYTES_PER_RESULT));

        unique case (state_reg)
            S_IDLE:
            begin
                // Bytes after the end code or an overflow are taken and dropped.
                if (in_valid && !done_reg)
                begin
                    if (have_code)
                    begin
                        bit_buffer_next = buf_merged >> code_width_reg;
                        bits_held_next = held_sum - HELD_W'(code_width_reg);
                        code_next = code_now;
                        state_next = S_DECODE;
                    end
                    else
                    begin
                        bit_buffer_next = buf_merged;
                        bits_held_next = held_sum;
                    end
                end
            end

            S_DECODE:
            begin
                // Pack setup shared by every path that ends in emitted bytes.
                issued_next = '0;
                packed_next = '0;
                rd_pend_next = 1'b0;
                word_next = '0;
                if (expect_lit_reg)
                begin
                    // The code right after a clear is one literal byte.
                    expect_lit_next = 1'b0;
                    stk_we = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = code_reg[BYTE_W-1:0];
                    prev_code_next = {{(CODE_W-BYTE_W){1'b0}}, code_reg[BYTE_W-1:0]};
                    prev_first_next = code_reg[BYTE_W-1:0];
                    have_prev_next = 1'b1;
                    remain_next = CNT_W'(1);
                    state_next = S_EMIT;
                end
                else if (code_reg == CODE_W'(CODE_END))
                begin
                    done_next = 1'b1;
                    out_bytes_next = '0;
                    byte_count_next = '0;
                    last_next = 1'b1;
                    end_next = 1'b1;
                    err_next = 1'b0;
                    state_next = S_OUT;
                end
                else if (code_reg == CODE_W'(CODE_CLEAR))
                begin
                    next_free_next = FREE_W'(FIRST_FREE);
                    code_width_next = CW_W'(START_WIDTH);
                    threshold_next = FREE_W'(START_THRESHOLD);
                    have_prev_next = 1'b0;
                    prev_code_next = '0;
                    prev_first_next = '0;
                    expect_lit_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!is_known && !have_prev_reg)
                begin
                    // An unknown code with no previous string decodes to nothing.
                    state_next = S_IDLE;
                end
                else
                begin
                    known_next = is_known;
                    if (is_known)
                    begin
                        depth_next = '0;
                    end
                    else
                    begin
                        // An unknown code ends in the previous string's first byte.
                        stk_we = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = prev_first_reg;
                        depth_next = CNT_W'(1);
                    end
                    walk_code_next = walk_start;
                    if (walk_start < CODE_W'(LIT_LIMIT))
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        tbl_re = 1'b1;
                        tbl_raddr = walk_start;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                // The entry read last cycle gives one byte and the next link.
                if (depth_reg >= CNT_W'(MAX_STRING))
                begin
                    done_next = 1'b1;
                    out_bytes_next = '0;
                    byte_count_next = '0;
                    last_next = 1'b1;
                    end_next = 1'b0;
                    err_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    stk_we = 1'b1;
                    stk_wdata = tbl_suffix_q;
                    depth_next = depth_reg + CNT_W'(1);
                    walk_code_next = tbl_prefix_q;
                    if (tbl_prefix_q < CODE_W'(LIT_LIMIT))
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        tbl_re = 1'b1;
                        tbl_raddr = tbl_prefix_q;
                    end
                end
            end

            S_TAIL:
            begin
                // The chain ends in a single-byte code, the string's first byte.
                if (depth_reg >= CNT_W'(MAX_STRING))
                begin
                    done_next = 1'b1;
                    out_bytes_next = '0;
                    byte_count_next = '0;
                    last_next = 1'b1;
                    end_next = 1'b0;
                    err_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    stk_we = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (add_ok && (!known_reg || have_prev_reg))
                begin
                    tbl_we = 1'b1;
                    next_free_next = free_inc;
                    if ((free_inc >= threshold_reg)
                        && (code_width_reg != CW_W'(MAX_CODE_BITS)))
                    begin
                        code_width_next = code_width_reg + CW_W'(1);
                        threshold_next = threshold_reg << 1;
                    end
                end
                if (known_reg)
                begin
                    prev_code_next = code_reg;
                    prev_first_next = walk_code_reg[BYTE_W-1:0];
                    have_prev_next = 1'b1;
                end
                else if (add_ok)
                begin
                    prev_code_next = next_free_reg[CODE_W-1:0];
                end
                remain_next = depth_reg;
                issued_next = '0;
                packed_next = '0;
                rd_pend_next = 1'b0;
                word_next = '0;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // Reads of the stack overlap with packing the byte read before.
                if (issue)
                begin
                    stk_re = 1'b1;
                    remain_next = remain_dec;
                    issued_next = issued_reg + BCNT_W'(1);
                    rd_pend_next = 1'b1;
                    word_next = word_acc;
                    packed_next = packed_acc;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    out_bytes_next = word_acc;
                    byte_count_next = packed_acc;
                    last_next = (remain_reg == '0);
                    end_next = 1'b0;
                    err_next = 1'b0;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        issued_next = '0;
                        packed_next = '0;
                        word_next = '0;
                        state_next = S_EMIT;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bit_buffer_reg <= '0;
            bits_held_reg  <= '0;
            code_width_reg <= CW_W'(START_WIDTH);
            next_free_reg  <= FREE_W'(FIRST_FREE);
            threshold_reg  <= FREE_W'(START_THRESHOLD);
            prev_code_reg  <= '0;
            prev_first_reg <= '0;
            have_prev_reg  <= 1'b0;
            expect_lit_reg <= 1'b0;
            done_reg       <= 1'b0;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_buffer_reg <= bit_buffer_next;
            bits_held_reg  <= bits_held_next;
            code_width_reg <= code_width_next;
            next_free_reg  <= next_free_next;
            threshold_reg  <= threshold_next;
            prev_code_reg  <= prev_code_next;
            prev_first_reg <= prev_first_next;
            have_prev_reg  <= have_prev_next;
            expect_lit_reg <= expect_lit_next;
            done_reg       <= done_next;
            rd_pend_reg    <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        known_reg      <= known_next;
        walk_code_reg  <= walk_code_next;
        depth_reg      <= depth_next;
        remain_reg     <= remain_next;
        issued_reg     <= issued_next;
        packed_reg     <= packed_next;
        word_reg       <= word_next;
        out_bytes_reg  <= out_bytes_next;
        byte_count_reg <= byte_count_next;
        last_reg       <= last_next;
        end_reg        <= end_next;
        err_reg        <= err_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign out_bytes      = out_bytes_reg;
    assign byte_count     = byte_count_reg;
    assign last_of_run    = last_reg;
    assign end_seen       = end_reg;
    assign overflow_error = err_reg;

endmodule

// ===== test/lzw_variable_width_decoder_test.sv =====
`timescale 1ns / 1ps

module lzw_variable_width_decoder_test;
    import lzwvd_pkg::*;

    // The block runs with its default dictionary and string sizes; the model of the
    // decoder below uses the same values.
    localparam int CODE_BITS = 12;
    localparam int STRING_LIMIT = 512;
    localparam int TABLE_SIZE = 1 << CODE_BITS;

    // Roughly how many compressed bytes the random stream carries.
    localparam int RANDOM_BYTES = 40;

    // The slowest single request walks a 512-byte string and sends 64 words, so this many
    // quiet cycles cover anything still in flight.
    localparam int DRAIN_CYCLES = 1200;

    // Upper bound on the whole run, set well beyond even a run in which every byte
    // unwound a 512-byte string under heavy stalls.
    localparam longint TIMEOUT_NS = 10_000_000;

    // Mismatch lines beyond this count are counted but not printed.
    localparam int REPORT_LIMIT = 40;

    typedef enum {
        STALL_NONE,
        STALL_RANDOM,
        STALL_ALTERNATE,
        STALL_HEAVY
    } stall_mode_t;

    // One output word as the block should deliver it.
    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        done;
        logic        overflow;
    } decoded_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic        end_seen;
    logic        overflow_error;

    lzw_variable_width_decoder #(
        .MAX_CODE_BITS(CODE_BITS),
        .MAX_STRING(STRING_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_bytes(out_bytes),
        .byte_count(byte_count),
        .last_of_run(last_of_run),
        .end_seen(end_seen),
        .overflow_error(overflow_error)
    );

    // Words the decoder still owes, oldest first.
    decoded_word_t decoded_words[$];
    int error_count = 0;

    // Number of compressed bytes the block has taken so far.
    int bytes_accepted = 0;
    // Requests left in the sender's current burst.
    int burst_left = 0;
    // When set, the receiver holds off for this many cycles regardless of its pattern.
    int hold_cycles = 0;

    // Decoder model: bit gathering, dictionary and the string being unwound.
    logic [19:0] acc_bits = '0;
    logic [4:0]  acc_count = '0;
    logic [3:0]  cur_width = 4'(START_WIDTH);
    logic [12:0] free_code = 13'(FIRST_FREE);
    logic [12:0] grow_at = 13'(START_THRESHOLD);
    logic [11:0] prefix_mem[TABLE_SIZE];
    logic [7:0]  suffix_mem[TABLE_SIZE];
    logic [7:0]  chain_buf[STRING_LIMIT];
    logic [11:0] last_code = '0;
    logic [7:0]  last_first = '0;
    logic        have_last = 1'b0;
    logic        want_literal = 1'b0;
    logic        halted = 1'b0;

    // Encoder side: tracks the code width the decoder will use for the next code, so
    // that the test can pack codes into bytes the way a compressor would.
    int unsigned enc_width = START_WIDTH;
    int unsigned enc_next_free = FIRST_FREE;
    int unsigned enc_grow_at = START_THRESHOLD;
    bit          enc_has_prev = 1'b0;
    bit          enc_literal_due = 1'b0;
    logic [31:0] pack_acc = '0;
    int unsigned pack_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic void restart_dictionary();
        free_code = 13'(FIRST_FREE);
        cur_width = 4'(START_WIDTH);
        grow_at = 13'(START_THRESHOLD);
        have_last = 1'b0;
        last_code = '0;
        last_first = '0;
    endfunction

    // Adds one dictionary entry and widens the codes when the next free code reaches
    // the current threshold. A full dictionary takes no more entries.
    function automatic void add_word(input logic [11:0] prefix, input logic [7:0] suffix);
        if (free_code >= 13'(TABLE_SIZE))
            return;
        prefix_mem[free_code[11:0]] = prefix;
        suffix_mem[free_code[11:0]] = suffix;
        free_code = free_code + 13'd1;
        if (free_code >= grow_at && cur_width != 4'(CODE_BITS))
        begin
            cur_width = cur_width + 4'd1;
            grow_at = grow_at << 1;
        end
    endfunction

    // Unwinds the string of a code into chain_buf from the given depth on, last byte
    // first. Returns the new depth, or -1 once the string would exceed the limit.
    function automatic int walk_chain(input logic [11:0] code, input int depth);
        logic [11:0] c;
        c = code;
        while (1)
        begin
            if (depth >= STRING_LIMIT)
                return -1;
            if (c < 12'(LIT_LIMIT))
            begin
                chain_buf[depth] = c[7:0];
                return depth + 1;
            end
            chain_buf[depth] = suffix_mem[c];
            depth++;
            c = prefix_mem[c];
        end
    endfunction

    // Packs the unwound string, first byte first, into words of up to eight bytes.
    function automatic int queue_chain(input int depth);
        decoded_word_t w;
        int i;
        int words;
        i = depth;
        words = 0;
        while (i > 0)
        begin
            w = '{default: '0};
            while (w.count < BYTES_PER_RESULT && i > 0)
            begin
                i--;
                w.data[8 * w.count +: 8] = chain_buf[i];
                w.count = w.count + 4'd1;
            end
            decoded_words.push_back(w);
            words++;
        end
        return words;
    endfunction

    // End of stream and string overflow both report one empty word and stop the
    // decoder for good.
    function automatic void halt_with_flag(input logic done, input logic overflow);
        decoded_word_t w;
        w = '{default: '0};
        w.last = 1'b1;
        w.done = done;
        w.overflow = overflow;
        halted = 1'b1;
        decoded_words.push_back(w);
    endfunction

    // Takes one accepted compressed byte and queues every word it should produce.
    function automatic void decode_stream_byte(input logic [7:0] value);
        logic [11:0] code;
        logic [12:0] added;
        logic [7:0]  first;
        int depth;
        int words;
        if (halted)
            return;
        acc_bits = acc_bits | (20'(value) << acc_count);
        acc_count = acc_count + 5'd8;
        if (acc_count < 5'(cur_width))
            return;
        code = 12'(acc_bits & ((20'd1 << cur_width) - 20'd1));
        acc_bits = acc_bits >> cur_width;
        acc_count = acc_count - 5'(cur_width);
        words = 0;

        if (want_literal)
        begin
            // The code right after a clear is always a plain byte, even 0x100 or 0x101.
            want_literal = 1'b0;
            chain_buf[0] = code[7:0];
            last_code = {4'd0, code[7:0]};
            last_first = code[7:0];
            have_last = 1'b1;
            words = queue_chain(1);
        end
        else if (code == 12'(CODE_END))
        begin
            halt_with_flag(1'b1, 1'b0);
        end
        else if (code == 12'(CODE_CLEAR))
        begin
            restart_dictionary();
            want_literal = 1'b1;
        end
        else if (code < 12'(LIT_LIMIT) || (code >= 12'(FIRST_FREE) && 13'(code) < free_code))
        begin
            depth = walk_chain(code, 0);
            if (depth < 0)
                halt_with_flag(1'b0, 1'b1);
            else
            begin
                first = chain_buf[depth - 1];
                if (have_last)
                    add_word(last_code, first);
                last_code = code;
                last_first = first;
                have_last = 1'b1;
                words = queue_chain(depth);
            end
        end
        else if (have_last)
        begin
            // A code not yet in the dictionary stands for the previous string plus
            // its own first byte.
            chain_buf[0] = last_first;
            depth = walk_chain(last_code, 1);
            if (depth < 0)
                halt_with_flag(1'b0, 1'b1);
            else
            begin
                if (free_code < 13'(TABLE_SIZE))
                begin
                    added = free_code;
                    add_word(last_code, last_first);
                    last_code = added[11:0];
                end
                words = queue_chain(depth);
            end
        end
        if (words > 0)
            decoded_words[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    function automatic void track_entry();
        if (enc_next_free < TABLE_SIZE)
        begin
            enc_next_free++;
            if (enc_next_free >= enc_grow_at && enc_width != CODE_BITS)
            begin
                enc_width++;
                enc_grow_at = enc_grow_at * 2;
            end
        end
    endfunction

    // Follows what one code does to the code width and the dictionary fill level.
    function automatic void track_code(input int unsigned code);
        if (enc_literal_due)
        begin
            enc_literal_due = 1'b0;
            enc_has_prev = 1'b1;
        end
        else if (code == CODE_CLEAR)
        begin
            enc_next_free = FIRST_FREE;
            enc_width = START_WIDTH;
            enc_grow_at = START_THRESHOLD;
            enc_has_prev = 1'b0;
            enc_literal_due = 1'b1;
        end
        else if (code == CODE_END)
        begin
            enc_has_prev = enc_has_prev;
        end
        else if (code < LIT_LIMIT || (code >= FIRST_FREE && code < enc_next_free))
        begin
            if (enc_has_prev)
                track_entry();
            enc_has_prev = 1'b1;
        end
        else if (enc_has_prev)
        begin
            track_entry();
        end
    endfunction

    // Sends one compressed byte as a request. The sender works in bursts; between
    // bursts it may drop valid for a random gap. The byte goes to the decoder model
    // at the edge where the block takes it.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte <= value;
        do
            @(posedge clk);
        while (in_stall);
        bytes_accepted++;
        decode_stream_byte(value);
    endtask

    // Appends one code at the width the decoder will read it with, least significant
    // bit first, and sends every byte that is complete.
    task automatic put_code(input int unsigned code);
        pack_acc = pack_acc | (32'(code) << pack_count);
        pack_count += enc_width;
        track_code(code);
        while (pack_count >= 8)
        begin
            send_byte(pack_acc[7:0]);
            pack_acc = pack_acc >> 8;
            pack_count -= 8;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed opening: codes with and without a previous string, byte extremes, a
    // code that is not yet in the dictionary, and the reserved codes used as the
    // literal that follows a clear.
    task automatic test_start_of_stream();
        put_code(300);                  // unknown, nothing before it: no output
        put_code(8'h41);                // known, nothing before it: no new entry
        put_code(8'h00);
        put_code(8'hff);
        put_code(enc_next_free);        // code that is being defined right now
        put_code(FIRST_FREE);           // two-byte entry
        put_code(FIRST_FREE + 2);
        put_code(511);                  // far past the dictionary end
        put_code(CODE_CLEAR);
        put_code(CODE_END);             // read as the byte 0x01
        put_code(CODE_CLEAR);
        put_code(CODE_CLEAR);           // read as the byte 0x00
        put_code(CODE_CLEAR);
        put_code(511);                  // read as the byte 0xff
        put_code(FIRST_FREE);           // unknown right after the literal
        put_code(CODE_CLEAR);
        put_code(CODE_CLEAR);
        put_code(8'h80);
        put_code(enc_next_free);
    endtask

    // Random stream, mostly well formed: plain bytes, dictionary entries, codes being
    // defined, clears, and now and then any code at all. End of stream is held back
    // for the last test. The receiver holds off at the start so that the block
    // backs up and stalls its input.
    task automatic test_random_stream();
        int goal;
        int unsigned top;
        int unsigned roll;
        int unsigned code;
        goal = bytes_accepted + RANDOM_BYTES;
        hold_cycles = 400;
        while (bytes_accepted < goal)
        begin
            top = (1 << enc_width) - 1;
            roll = $urandom_range(0, 99);
            if (enc_literal_due)
                code = $urandom_range(0, top);
            else if (roll < 40)
                code = $urandom_range(0, LIT_LIMIT - 1);
            else if (roll < 70 && enc_next_free > FIRST_FREE)
                code = $urandom_range(FIRST_FREE, enc_next_free - 1);
            else if (roll < 82 && enc_next_free <= top)
                code = enc_next_free;
            else if (roll < 87)
                code = CODE_CLEAR;
            else
            begin
                code = $urandom_range(0, top);
                if (code == CODE_END)
                    code = CODE_CLEAR;
            end
            put_code(code);
        end
    endtask

    // Builds a long string: each code that is being defined adds one byte to the
    // previous string, so the last request spans four words.
    task automatic test_long_string();
        put_code(CODE_CLEAR);
        put_code($urandom_range(0, 511));
        repeat (30) put_code(enc_next_free);
    endtask

    // End of stream, then bytes that the block must ignore.
    task automatic test_end_of_stream();
        put_code(CODE_END);
        if (pack_count > 0)
            send_byte(pack_acc[7:0]);
        pack_acc = '0;
        pack_count = 0;
        repeat (6) send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls on a pattern that changes at random intervals, and
    // holds off completely while hold_cycles runs down.
    // ------------------------------------------------------------------

    initial
    begin : receiver
        stall_mode_t mode;
        int mode_left;
        int phase;
        logic stall_next;
        mode = STALL_NONE;
        mode_left = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            phase++;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                stall_next = 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_RANDOM:    stall_next = ($urandom_range(0, 2) == 0);
                    STALL_ALTERNATE: stall_next = phase[0];
                    STALL_HEAVY:     stall_next = ($urandom_range(0, 3) != 0);
                    default:         stall_next = 1'b0;
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Result check: every word the block hands over is compared with the oldest
    // one still owed.
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_words
        decoded_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_words.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t ns: word with no word owed, actual bytes %0h count %0d",
                             $time, out_bytes, byte_count);
            end
            else
            begin
                want = decoded_words.pop_front();
                check_field("out_bytes", want.data, out_bytes);
                check_field("byte_count", 64'(want.count), 64'(byte_count));
                check_field("last_of_run", 64'(want.last), 64'(last_of_run));
                check_field("end_seen", 64'(want.done), 64'(end_seen));
                check_field("overflow_error", 64'(want.overflow), 64'(overflow_error));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_start_of_stream();
        test_random_stream();
        test_long_string();
        test_end_of_stream();

        @(negedge clk);
        in_valid <= 1'b0;

        // Let every owed word come out, then watch for strays.
        while (decoded_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (decoded_words.size() == 0 && error_count == 0)
            $display("lzw_variable_width_decoder test passed");
        else
            $display("lzw_variable_width_decoder test failed");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("lzw_variable_width_decoder test failed");
        $finish;
    end

endmodule

// ===== lzw_variable_width_decoder.f =====
rtl/core/lzwvd_pkg.sv
rtl/core/lzwvd_dict.sv
rtl/core/lzw_variable_width_decoder.sv
test/lzw_variable_width_decoder_test.sv
